/* rtl/core/spicrc_pkg.sv */
// Shared constants, types and the CRC-8 step for the SPI frame exchange engine.
package spicrc_pkg;

	typedef logic [3:0] pos_t;
	typedef logic [1:0] reg_idx_t;

	localparam logic [7:0] FRAME_HEADER = 8'h45;
	localparam logic [7:0] CRC_POLY     = 8'h07;
	localparam pos_t       LAST_POS     = 4'd13;
	localparam int         STAGE_BYTES  = 12;
	localparam int         NUM_WORDS    = 3;

	localparam reg_idx_t REG_REPLY_WORD0 = 2'd0;
	localparam reg_idx_t REG_REPLY_WORD1 = 2'd1;
	localparam reg_idx_t REG_REPLY_WORD2 = 2'd2;

	// CRC-8, MSB first, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/spi_crc8_frame_exchange.sv */
// Top level: 14-byte full-duplex frame engine with CRC-8 check and reply generation.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per transfer.
//   Output channel (out_valid/out_ready) returns one reply transfer per input byte:
//   tx_byte for the same frame position, frame_end/crc_ok on the closing byte, and the
//   committed payload words and frame counters as they stand after that byte.
//   Reply frame: header 0x45, reply_word0..2 little-endian, CRC-8 (poly 0x07) over 13 bytes.
//   A received frame whose byte 13 matches the CRC of bytes 0..12 commits its 12 payload
//   bytes to rx_word0..2 and bumps good_frames; otherwise bad_frames counts up.
//   Path: input transfer -> input register -> result register -> result valid.
//   Throughput: one byte per cycle if not stalled; CRC step: one 8-bit combinational stage.
//   Receiver stall: the result register holds; the input register keeps accepting until
//   it holds a byte that cannot move on, then in_ready drops.
//   Reset: frame position, CRCs, staging, committed words, counters and reply words clear.
//   APB registers reply_word0..2 at byte offsets 0x0, 0x4, 0x8; pready is always high.
module spi_crc8_frame_exchange
	import spicrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// received byte channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// reply channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        frame_end,
	output logic        crc_ok,
	output logic [31:0] rx_word0,
	output logic [31:0] rx_word1,
	output logic [31:0] rx_word2,
	output logic [31:0] good_frames,
	output logic [31:0] bad_frames
);

	logic [31:0] reply_q [NUM_WORDS];
	reg_idx_t    cfg_idx;
	logic        cfg_wr;

	logic        valid_s1;
	logic [7:0]  rx_s1;
	logic        adv_s1;

	logic        out_valid_q;
	logic [7:0]  tx_byte_q;
	logic        frame_end_q;
	logic        crc_ok_q;

	pos_t        pos_q;
	logic [7:0]  rx_crc_q;
	logic [7:0]  tx_crc_q;
	logic [7:0]  staging_q [STAGE_BYTES];
	logic [31:0] commit_q [NUM_WORDS];
	logic [31:0] good_q;
	logic [31:0] bad_q;

	logic        last_c;
	logic        first_c;
	logic [3:0]  k_c;
	logic [31:0] word_c;
	logic [7:0]  tx_c;
	logic        match_c;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			REG_REPLY_WORD0: prdata = reply_q[0];
			REG_REPLY_WORD1: prdata = reply_q[1];
			REG_REPLY_WORD2: prdata = reply_q[2];
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				reply_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_REPLY_WORD0: reply_q[0] <= pwdata;
				REG_REPLY_WORD1: reply_q[1] <= pwdata;
				REG_REPLY_WORD2: reply_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	// input register
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	// per-byte work: reply byte select, CRC steps, frame close
	assign last_c  = (pos_q >= LAST_POS);
	assign first_c = (pos_q == '0);
	assign k_c     = pos_q - 4'd1;

	always_comb begin
		unique case (k_c[3:2])
			2'd0:    word_c = reply_q[0];
			2'd1:    word_c = reply_q[1];
			2'd2:    word_c = reply_q[2];
			default: word_c = '0;
		endcase
	end

	always_comb begin
		priority if (first_c) begin
			tx_c = FRAME_HEADER;
		end else if (!last_c) begin
			tx_c = word_c[{k_c[1:0], 3'b000} +: 8];
		end else begin
			tx_c = tx_crc_q;
		end
	end

	assign match_c = (rx_crc_q == rx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			rx_crc_q <= '0;
			tx_crc_q <= '0;
			good_q   <= '0;
			bad_q    <= '0;
			for (int i = 0; i < STAGE_BYTES; i++) begin
				staging_q[i] <= '0;
			end
			for (int i = 0; i < NUM_WORDS; i++) begin
				commit_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (!last_c) begin
				tx_crc_q <= crc8_update(first_c ? 8'h00 : tx_crc_q, tx_c);
				rx_crc_q <= crc8_update(first_c ? 8'h00 : rx_crc_q, rx_s1);
				for (int i = 0; i < STAGE_BYTES; i++) begin
					if (pos_q == pos_t'(i + 1)) begin
						staging_q[i] <= rx_s1;
					end
				end
				pos_q <= pos_q + 4'd1;
			end else begin
				if (match_c) begin
					for (int i = 0; i < NUM_WORDS; i++) begin
						commit_q[i] <= {staging_q[4*i+3], staging_q[4*i+2],
							staging_q[4*i+1], staging_q[4*i]};
					end
					good_q <= good_q + 32'd1;
				end else begin
					bad_q <= bad_q + 32'd1;
				end
				rx_crc_q <= '0;
				tx_crc_q <= '0;
				pos_q    <= '0;
			end
		end
	end

	// result register; words and counters are read straight from state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tx_byte_q   <= tx_c;
			frame_end_q <= last_c;
			crc_ok_q    <= last_c && match_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_byte     = tx_byte_q;
	assign frame_end   = frame_end_q;
	assign crc_ok      = crc_ok_q;
	assign rx_word0    = commit_q[0];
	assign rx_word1    = commit_q[1];
	assign rx_word2    = commit_q[2];
	assign good_frames = good_q;
	assign bad_frames  = bad_q;

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("frame position out of range");

	a_ok_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && crc_ok_q |-> frame_end_q)
		else $error("crc_ok without frame end");

	a_good_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_c && match_c |=> good_q == $past(good_q) + 32'd1 && crc_ok_q)
		else $error("good frame not counted");

	a_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_c && !match_c |=> bad_q == $past(bad_q) + 32'd1 && !crc_ok_q)
		else $error("bad frame not counted");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_c |=> pos_q == '0 && rx_crc_q == '0 && tx_crc_q == '0)
		else $error("frame state not cleared at frame end");

endmodule
